### hdl/bcc_pkg.sv
// ----------------------------------------------------------------------------
// bcc_pkg
// Shared widths, register indexes, reset values, release count limits, class
// codes and the configuration struct of the button click classifier.
// ----------------------------------------------------------------------------
`default_nettype none

package bcc_pkg;

  localparam int TIME_WIDTH    = 32;
  localparam int THR_WIDTH     = 32;
  localparam int STEP_WIDTH    = 16;
  localparam int CNT_WIDTH     = 8;
  localparam int CFG_IDX_WIDTH = 3;
  localparam int CFG_DATA_WIDTH = 32;
  localparam int CMP_WIDTH     = (TIME_WIDTH > THR_WIDTH) ? TIME_WIDTH : THR_WIDTH;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_WIDTH-1:0] REG_PRESSED_LEVEL    = 3'd0;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_TICK_STEP        = 3'd1;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_LONG_THRESHOLD   = 3'd2;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_SHORT_THRESHOLD  = 3'd3;
  localparam logic [CFG_IDX_WIDTH-1:0] REG_DOUBLE_THRESHOLD = 3'd4;

  // reset values of the registers
  localparam logic                  RST_PRESSED_LEVEL    = 1'b0;
  localparam logic [STEP_WIDTH-1:0] RST_TICK_STEP        = 16'd1;
  localparam logic [THR_WIDTH-1:0]  RST_LONG_THRESHOLD   = 32'd1000;
  localparam logic [THR_WIDTH-1:0]  RST_SHORT_THRESHOLD  = 32'd50;
  localparam logic [THR_WIDTH-1:0]  RST_DOUBLE_THRESHOLD = 32'd300;

  // release count limits
  localparam logic signed [CNT_WIDTH-1:0] CNT_MAX        = 8'sd127;
  localparam logic signed [CNT_WIDTH-1:0] CNT_AFTER_LONG = -8'sd1;
  localparam logic signed [CNT_WIDTH-1:0] CNT_ZERO       = 8'sd0;
  localparam logic signed [CNT_WIDTH-1:0] CNT_ONE        = 8'sd1;
  localparam logic signed [CNT_WIDTH-1:0] CNT_DOUBLE_MIN = 8'sd2;

  typedef enum logic [1:0] {
    CLS_RELEASED = 2'd0,
    CLS_PRESSED  = 2'd1,
    CLS_LONG     = 2'd2,
    CLS_DOUBLE   = 2'd3
  } cls_t;

  typedef struct packed {
    logic                  pressed_level;
    logic [STEP_WIDTH-1:0] tick_step;
    logic [THR_WIDTH-1:0]  long_threshold;
    logic [THR_WIDTH-1:0]  short_threshold;
    logic [THR_WIDTH-1:0]  double_threshold;
  } cfg_t;

endpackage

`default_nettype wire

### hdl/bcc_cfg_regs.sv
// ----------------------------------------------------------------------------
// bcc_cfg_regs
// Configuration register file: decodes the write channel into the five
// classifier settings.
// ----------------------------------------------------------------------------
`default_nettype none

module bcc_cfg_regs (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               cfg_valid,
  input  wire logic [bcc_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
  input  wire logic [bcc_pkg::CFG_DATA_WIDTH-1:0] cfg_data,
  output bcc_pkg::cfg_t                           cfg
);
  import bcc_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pressed_level    <= RST_PRESSED_LEVEL;
      cfg.tick_step        <= RST_TICK_STEP;
      cfg.long_threshold   <= RST_LONG_THRESHOLD;
      cfg.short_threshold  <= RST_SHORT_THRESHOLD;
      cfg.double_threshold <= RST_DOUBLE_THRESHOLD;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PRESSED_LEVEL:    cfg.pressed_level    <= cfg_data[0];
        REG_TICK_STEP:        cfg.tick_step        <= cfg_data[STEP_WIDTH-1:0];
        REG_LONG_THRESHOLD:   cfg.long_threshold   <= cfg_data[THR_WIDTH-1:0];
        REG_SHORT_THRESHOLD:  cfg.short_threshold  <= cfg_data[THR_WIDTH-1:0];
        REG_DOUBLE_THRESHOLD: cfg.double_threshold <= cfg_data[THR_WIDTH-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

### hdl/button_click_classifier_top.sv
// ----------------------------------------------------------------------------
// button_click_classifier_top
// Debounces a sampled button pin and classifies it as released, pressed,
// long pressed or double clicked.
// ----------------------------------------------------------------------------
// Usage:
//   input channel  in_valid/in_stall carries one pin_level sample per transfer
//   output channel out_valid/out_stall returns button_state and release_count,
//     exactly one result per accepted sample, in order
//   config channel cfg_valid/cfg_ready writes cfg_index/cfg_data; cfg_ready is
//     always high, write only while the block is idle
// Path: an accepted sample sits in the input register, and its result is
//   written to the result register once that register can take it.
// Throughput: one sample per cycle unless stalled; the state update is one
//   32-bit add plus three parallel threshold compares between input and result registers.
// Stall: while out_stall holds a result, the input register still takes one
//   more sample; after that in_stall rises until the result is taken.
// Reset: synchronous rst clears history, count, elapsed time and class, loads
//   the default settings and empties both pipeline registers.
// ----------------------------------------------------------------------------
`default_nettype none

module button_click_classifier_top (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output      logic                               in_stall,
  input  wire logic                               pin_level,
  output      logic                               out_valid,
  input  wire logic                               out_stall,
  output      logic [1:0]                         button_state,
  output      logic signed [7:0]                  release_count,
  input  wire logic                               cfg_valid,
  output      logic                               cfg_ready,
  input  wire logic [bcc_pkg::CFG_IDX_WIDTH-1:0]  cfg_index,
  input  wire logic [bcc_pkg::CFG_DATA_WIDTH-1:0] cfg_data
);
  import bcc_pkg::*;

  cfg_t cfg;

  // input register
  logic s1_valid;
  logic s1_level;

  // classifier state; elapsed is press time since the last event mark
  logic [2:0]                   hist;
  logic signed [CNT_WIDTH-1:0]  rel;
  logic [TIME_WIDTH-1:0]        elapsed;
  cls_t                         cls;

  logic [2:0]                   hist_next;
  logic signed [CNT_WIDTH-1:0]  rel_next;
  logic [TIME_WIDTH-1:0]        elapsed_next;
  cls_t                         cls_next;

  logic [TIME_WIDTH-1:0]        el_sum;
  logic                         is_release;
  logic                         is_hold;
  logic                         gt_long;
  logic                         gt_short;
  logic                         gt_double;

  logic out_ready;
  logic s1_ready;
  logic advance;

  assign cfg_ready = 1'b1;

  bcc_cfg_regs u_cfg_regs (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  assign out_ready = !out_valid || !out_stall;
  assign advance   = s1_valid && out_ready;
  assign s1_ready  = !s1_valid || out_ready;
  assign in_stall  = !s1_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && in_valid) begin
      s1_level <= pin_level;
    end
  end

  always_comb begin
    el_sum     = elapsed + TIME_WIDTH'(cfg.tick_step);
    gt_long    = CMP_WIDTH'(el_sum) > CMP_WIDTH'(cfg.long_threshold);
    gt_short   = CMP_WIDTH'(el_sum) > CMP_WIDTH'(cfg.short_threshold);
    gt_double  = CMP_WIDTH'(el_sum) > CMP_WIDTH'(cfg.double_threshold);
    is_release = (s1_level != cfg.pressed_level) && (s1_level != hist[2]);
    is_hold    = (s1_level == cfg.pressed_level) && (hist[1] == s1_level) &&
                 (hist[2] == s1_level);

    hist_next    = {s1_level, hist[2:1]};
    rel_next     = rel;
    elapsed_next = elapsed;
    cls_next     = cls;

    if (is_release) begin
      if (rel != CNT_MAX) begin
        rel_next = rel + CNT_ONE;
      end
      cls_next = CLS_RELEASED;
    end else if (is_hold) begin
      elapsed_next = el_sum;
      // first matching test decides, even when the class is already set
      if (gt_long && rel == CNT_ZERO) begin
        if (cls != CLS_LONG) begin
          cls_next     = CLS_LONG;
          rel_next     = CNT_AFTER_LONG;
          elapsed_next = '0;
        end
      end else if (gt_short && rel == CNT_ONE) begin
        if (cls != CLS_PRESSED) begin
          cls_next     = CLS_PRESSED;
          rel_next     = CNT_ZERO;
          elapsed_next = '0;
        end
      end else if (!gt_double && rel >= CNT_DOUBLE_MIN) begin
        if (cls != CLS_DOUBLE) begin
          cls_next     = CLS_DOUBLE;
          rel_next     = CNT_ZERO;
          elapsed_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hist    <= '0;
      rel     <= CNT_ZERO;
      elapsed <= '0;
      cls     <= CLS_RELEASED;
    end else if (advance) begin
      hist    <= hist_next;
      rel     <= rel_next;
      elapsed <= elapsed_next;
      cls     <= cls_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_ready) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      button_state  <= cls_next;
      release_count <= rel_next;
    end
  end

endmodule

`default_nettype wire

### hdl/bcc_checker.sv
// ----------------------------------------------------------------------------
// bcc_checker
// Port-level checks of the button click classifier, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bcc_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              out_valid,
  input wire logic              out_stall,
  input wire logic [1:0]        button_state,
  input wire logic signed [7:0] release_count
);
  import bcc_pkg::*;

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(button_state) &&
      $stable(release_count))
    else $error("stalled result changed");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  // count never drops below minus one
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(release_count[7] && release_count != CNT_AFTER_LONG))
    else $error("release count out of range");

  // a classified event always comes with its matching count
  a_class_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && button_state != CLS_RELEASED |->
      (button_state == CLS_LONG && release_count == CNT_AFTER_LONG) ||
      (button_state != CLS_LONG && release_count == CNT_ZERO))
    else $error("class and release count disagree");

endmodule

bind button_click_classifier_top bcc_checker u_bcc_checker (.*);

`default_nettype wire

### bench/tb_button_click_classifier_top.sv
// ----------------------------------------------------------------------------
// tb_button_click_classifier_top
// Self-checking bench for the button click classifier. A tracker class keeps
// its own copy of the debounce history, release count, press-time total and
// event mark. It predicts state and count for every accepted pin sample and
// checks each returned result in order. Stimulus runs through several
// settings phases: a short directed start, then random click, hold,
// double-click, chatter and noise gestures. A long chatter run drives the
// count to saturation and a long hold runs at the largest step. Both
// channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_button_click_classifier_top;
  import bcc_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int PHASE_ITEMS  = 120;
  localparam int LONG_HOLD    = 100;
  localparam int DRAIN_CYCLES = 6;
  localparam int REG_COUNT    = 5;
  localparam int REPORT_LIMIT = 40;

  typedef enum int {GEST_CLICK, GEST_HOLD, GEST_DOUBLE, GEST_CHATTER, GEST_NOISE} gesture_t;
  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PERIODIC, STALL_LONG} stall_mode_t;

  typedef struct {
    cls_t                        state;
    logic signed [CNT_WIDTH-1:0] count;
  } click_result_t;

  class click_tracker;
    logic                        pressed_lvl;
    logic [STEP_WIDTH-1:0]       step;
    logic [THR_WIDTH-1:0]        long_thr;
    logic [THR_WIDTH-1:0]        short_thr;
    logic [THR_WIDTH-1:0]        dbl_thr;
    logic [2:0]                  hist;
    logic signed [CNT_WIDTH-1:0] releases;
    logic [TIME_WIDTH-1:0]       press_total;
    logic [TIME_WIDTH-1:0]       event_mark;
    cls_t                        cls;
    click_result_t               expected_clicks[$];
    int                          errors;
    int                          checked;
    int                          saturated;
    int                          class_hits[4];

    function new();
      pressed_lvl = RST_PRESSED_LEVEL;
      step        = RST_TICK_STEP;
      long_thr    = RST_LONG_THRESHOLD;
      short_thr   = RST_SHORT_THRESHOLD;
      dbl_thr     = RST_DOUBLE_THRESHOLD;
      hist        = '0;
      releases    = CNT_ZERO;
      press_total = '0;
      event_mark  = '0;
      cls         = CLS_RELEASED;
      errors      = 0;
      checked     = 0;
      saturated   = 0;
      foreach (class_hits[i]) class_hits[i] = 0;
    endfunction

    function void apply_config(input logic [CFG_IDX_WIDTH-1:0] idx,
                               input logic [CFG_DATA_WIDTH-1:0] data);
      case (idx)
        REG_PRESSED_LEVEL:    pressed_lvl = data[0];
        REG_TICK_STEP:        step = data[STEP_WIDTH-1:0];
        REG_LONG_THRESHOLD:   long_thr = data[THR_WIDTH-1:0];
        REG_SHORT_THRESHOLD:  short_thr = data[THR_WIDTH-1:0];
        REG_DOUBLE_THRESHOLD: dbl_thr = data[THR_WIDTH-1:0];
        default: ;
      endcase
    endfunction

    // a matching test only acts when the class actually changes
    function void settle(input cls_t target, input logic signed [CNT_WIDTH-1:0] cnt);
      if (cls != target) begin
        cls        = target;
        releases   = cnt;
        event_mark = press_total;
      end
    endfunction

    function void note_sample(input logic lvl);
      logic                  prev_newest;
      logic [TIME_WIDTH-1:0] elapsed;
      click_result_t         r;
      prev_newest = hist[2];
      hist = {lvl, hist[2:1]};
      if (lvl != pressed_lvl && lvl != prev_newest) begin
        if (releases < CNT_MAX) releases = releases + 8'sd1;
        cls = CLS_RELEASED;
      end
      if (lvl == pressed_lvl && hist[0] == lvl && hist[1] == lvl) begin
        press_total = press_total + TIME_WIDTH'(step);
        elapsed = press_total - event_mark;
        if (elapsed > long_thr && releases == CNT_ZERO)
          settle(CLS_LONG, CNT_AFTER_LONG);
        else if (elapsed > short_thr && releases == CNT_ONE)
          settle(CLS_PRESSED, CNT_ZERO);
        else if (elapsed <= dbl_thr && releases >= CNT_DOUBLE_MIN)
          settle(CLS_DOUBLE, CNT_ZERO);
      end
      r.state = cls;
      r.count = releases;
      expected_clicks.push_back(r);
    endfunction

    function void check_result(input logic [1:0] state,
                               input logic signed [CNT_WIDTH-1:0] count);
      click_result_t want;
      if (expected_clicks.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: result with nothing expected: state %0d count %0d",
                   $time, state, count);
        return;
      end
      want = expected_clicks.pop_front();
      checked++;
      if (state !== want.state) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: button_state expected %0d actual %0d", $time, want.state, state);
      end
      if (count !== want.count) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("%0t: release_count expected %0d actual %0d", $time, want.count, count);
      end
      class_hits[want.state]++;
      if (want.count == CNT_MAX) saturated++;
    endfunction

    function int outstanding();
      return expected_clicks.size();
    endfunction
  endclass

  logic                        clk       = 1'b0;
  logic                        rst       = 1'b1;
  logic                        in_valid  = 1'b0;
  logic                        pin_level = 1'b0;
  logic                        out_stall = 1'b0;
  logic                        cfg_valid = 1'b0;
  logic [CFG_IDX_WIDTH-1:0]    cfg_index = '0;
  logic [CFG_DATA_WIDTH-1:0]   cfg_data  = '0;
  logic                        in_stall;
  logic                        out_valid;
  logic [1:0]                  button_state;
  logic signed [CNT_WIDTH-1:0] release_count;
  logic                        cfg_ready;

  click_tracker tracker;
  int           sent_samples     = 0;
  int           settings_written = 0;
  int           burst_left       = 0;
  logic         pressed_now      = 1'b0;
  int           hold_max         = 24;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  button_click_classifier_top dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .pin_level     (pin_level),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .button_state  (button_state),
    .release_count (release_count),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // receiver stall pattern, switching to a random mode after each random span
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_span = 0;
  int          stall_tick = 0;

  always @(posedge clk) begin
    if (stall_span == 0) begin
      stall_mode = stall_mode_t'($urandom_range(0, 3));
      stall_span = $urandom_range(16, 160);
    end else begin
      stall_span = stall_span - 1;
    end
    stall_tick = stall_tick + 1;
    case (stall_mode)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_RANDOM:   out_stall <= ($urandom_range(0, 2) == 0);
      STALL_PERIODIC: out_stall <= (stall_tick % 7) >= 4;
      default:        out_stall <= (stall_tick % 30) < 14;
    endcase
  end

  // transfer monitor and watchdog
  int quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) tracker.note_sample(pin_level);
      if (out_valid && !out_stall) tracker.check_result(button_state, release_count);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles = 0;
      else
        quiet_cycles = quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("%0t: no transfer for %0d cycles", $time, IDLE_LIMIT);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // sender runs in bursts; valid drops for a random gap after each burst
  task automatic send_sample(input logic lvl);
    int gap;
    in_valid  <= 1'b1;
    pin_level <= lvl;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_samples++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 24);
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_run(input logic lvl, input int n);
    repeat (n) send_sample(lvl);
  endtask

  // leaves cfg_valid high so back-to-back writes keep one assignment per edge
  task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                           input logic [CFG_DATA_WIDTH-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    tracker.apply_config(idx, data);
  endtask

  // narrow registers get random upper bits, which the block must drop
  task automatic write_settings(input cfg_t c);
    write_reg(REG_PRESSED_LEVEL, ($urandom() & 32'hFFFF_FFFE) | 32'(c.pressed_level));
    write_reg(REG_TICK_STEP, ($urandom() & 32'hFFFF_0000) | 32'(c.tick_step));
    write_reg(REG_LONG_THRESHOLD, c.long_threshold);
    write_reg(REG_SHORT_THRESHOLD, c.short_threshold);
    write_reg(REG_DOUBLE_THRESHOLD, c.double_threshold);
    if ($urandom_range(0, 1) == 1)
      write_reg(CFG_IDX_WIDTH'($urandom_range(REG_COUNT, (1 << CFG_IDX_WIDTH) - 1)), $urandom());
    cfg_valid <= 1'b0;
    settings_written++;
  endtask

  // steps the clock first so the monitor has noted the last transfer
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic cfg_t make_cfg(input logic lvl, input logic [STEP_WIDTH-1:0] stp,
                                    input logic [THR_WIDTH-1:0] lng_t,
                                    input logic [THR_WIDTH-1:0] shrt_t,
                                    input logic [THR_WIDTH-1:0] dbl_t);
    cfg_t c;
    c.pressed_level    = lvl;
    c.tick_step        = stp;
    c.long_threshold   = lng_t;
    c.short_threshold  = shrt_t;
    c.double_threshold = dbl_t;
    return c;
  endfunction

  task automatic play_gesture(input gesture_t g);
    int reps;
    case (g)
      GEST_CLICK: begin
        send_run(pressed_now, $urandom_range(1, 12));
        send_run(!pressed_now, $urandom_range(1, 10));
      end
      GEST_HOLD: begin
        send_run(pressed_now, $urandom_range(1, hold_max));
        send_run(!pressed_now, $urandom_range(1, 6));
      end
      GEST_DOUBLE: begin
        reps = $urandom_range(2, 4);
        repeat (reps) begin
          send_run(pressed_now, $urandom_range(1, 4));
          send_run(!pressed_now, $urandom_range(1, 4));
        end
        send_run(pressed_now, $urandom_range(3, 10));
      end
      GEST_CHATTER: begin
        reps = $urandom_range(2, 20);
        repeat (reps) begin
          send_sample(pressed_now);
          send_sample(!pressed_now);
        end
      end
      default: begin
        reps = $urandom_range(1, 10);
        repeat (reps) send_sample(1'($urandom_range(0, 1)));
      end
    endcase
  endtask

  // chatter never gives three pressed samples in a row, so the count only climbs
  task automatic run_phase(input cfg_t c, input int items, input int chatter_pairs,
                           input int hold_ticks);
    int     target;
    int     pick;
    longint span;
    write_settings(c);
    pressed_now = c.pressed_level;
    if (c.tick_step == 0) begin
      hold_max = 24;
    end else begin
      span = longint'(c.long_threshold) / c.tick_step + 8;
      hold_max = (span > 120) ? 120 : int'(span);
    end
    repeat (chatter_pairs) begin
      send_sample(pressed_now);
      send_sample(!pressed_now);
    end
    if (hold_ticks > 0) send_run(pressed_now, hold_ticks);
    target = sent_samples + items;
    while (sent_samples < target) begin
      pick = $urandom_range(0, 15);
      if (pick < 4)       play_gesture(GEST_CLICK);
      else if (pick < 8)  play_gesture(GEST_HOLD);
      else if (pick < 12) play_gesture(GEST_DOUBLE);
      else if (pick < 14) play_gesture(GEST_CHATTER);
      else                play_gesture(GEST_NOISE);
    end
    drain();
  endtask

  initial begin
    bit reset_seq [6]  = '{0, 0, 0, 1, 1, 0};
    bit gesture_seq [19] = '{1, 1, 1, 0, 1, 1, 1, 1, 1, 1, 0, 1, 0, 1, 0, 1, 1, 1, 0};
    tracker = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // default settings: with history at zero the first low samples count as pressed
    foreach (reset_seq[i]) send_sample(reset_seq[i]);
    drain();

    // tiny thresholds so press, long press and double click all show up quickly
    write_settings(make_cfg(1'b1, 16'd2, 32'd6, 32'd1, 32'd8));
    foreach (gesture_seq[i]) send_sample(gesture_seq[i]);
    drain();

    run_phase(make_cfg(1'b0, 16'd1, 32'd1000, 32'd50, 32'd300), PHASE_ITEMS, 140, 0);
    run_phase(make_cfg(1'b1, 16'd1, 32'd30, 32'd4, 32'd25), PHASE_ITEMS, 0, 0);
    run_phase(make_cfg(1'b0, 16'd3, 32'd60, 32'd10, 32'd40), PHASE_ITEMS, 0, 0);
    run_phase(make_cfg(1'b1, 16'd0, 32'd0, 32'd0, 32'd0), PHASE_ITEMS, 0, 0);
    run_phase(make_cfg(1'b0, 16'hFFFF, '1, '1, '1), PHASE_ITEMS, 0, 0);
    run_phase(make_cfg(1'b1, 16'hFFFF, 32'd200000, 32'd70000, 32'd140000), PHASE_ITEMS, 0, 0);
    repeat (2)
      run_phase(make_cfg(1'($urandom_range(0, 1)), STEP_WIDTH'($urandom_range(1, 4)),
                         $urandom_range(10, 80), $urandom_range(0, 15),
                         $urandom_range(0, 60)), PHASE_ITEMS, 0, 0);
    run_phase(make_cfg(1'($urandom_range(0, 1)), STEP_WIDTH'($urandom()), $urandom(),
                       $urandom(), $urandom()), PHASE_ITEMS, 0, 0);
    // one long hold at the largest step
    run_phase(make_cfg(1'b1, 16'hFFFF, '1, '1, 32'h0010_0000), PHASE_ITEMS, 0, LONG_HOLD);

    $display("ran %0d pin samples through %0d settings phases, %0d results checked",
             sent_samples, settings_written, tracker.checked);
    $display("released %0d, pressed %0d, long %0d, double %0d; count at its top %0d times",
             tracker.class_hits[CLS_RELEASED], tracker.class_hits[CLS_PRESSED],
             tracker.class_hits[CLS_LONG], tracker.class_hits[CLS_DOUBLE], tracker.saturated);
    if (tracker.errors == 0 && tracker.outstanding() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
